[rtl/bounded_priority_insert_list_defines.svh]
// Assertion macros for the bounded priority insert list.
`ifndef BOUNDED_PRIORITY_INSERT_LIST_DEFINES_SVH
`define BOUNDED_PRIORITY_INSERT_LIST_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication, checked at every rising edge outside reset
`define BPIL_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("bpil check failed");
// Next-cycle implication
`define BPIL_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("bpil check failed");
`else
`define BPIL_ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define BPIL_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

[rtl/bpil_pkg.sv]
// Types, codes and helpers shared by the bounded priority insert list.
`default_nettype none

package bpil_pkg;

    // Command codes
    localparam logic [1:0] CMD_OFFER = 2'd0;
    localparam logic [1:0] CMD_READ  = 2'd1;
    localparam logic [1:0] CMD_CLEAR = 2'd2;
    localparam logic [1:0] CMD_NOP   = 2'd3;

    // Configuration register indexes
    localparam logic [1:0] CFG_MAX_ENTRIES = 2'd0;
    localparam logic [1:0] CFG_INV_FAR_SQ  = 2'd1;
    localparam logic [1:0] CFG_INV_PERIOD  = 2'd2;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    // Register reset values
    localparam logic [4:0]  MAX_ENTRIES_RST = 5'd1;
    localparam logic [31:0] INV_FAR_SQ_RST  = 32'd65536;
    localparam logic [23:0] INV_PERIOD_RST  = 24'd3355;

    // Width used for length, bound and index compares (covers depths up to 255)
    localparam int CMP_W = 8;

    // Input beat
    typedef struct packed {
        logic [1:0]  command;
        logic [15:0] slot_id;
        logic [31:0] distance_sq;
        logic [19:0] age_ms;
        logic [3:0]  read_index;
    } in_beat_t;

    // Result beat
    typedef struct packed {
        logic               accepted;
        logic [3:0]         position;
        logic [4:0]         entry_count;
        logic               entry_valid;
        logic signed [31:0] entry_importance;
        logic [15:0]        entry_slot;
    } out_beat_t;

    // One stored list entry
    typedef struct packed {
        logic signed [31:0] importance;
        logic [15:0]        slot;
    } entry_t;

    // Clamp an unsigned value to the positive Q16.16 range
    function automatic logic [31:0] sat_u31(input logic [63:0] v);
        return (v > 64'h0000_0000_7FFF_FFFF) ? 32'h7FFF_FFFF : v[31:0];
    endfunction

endpackage

`default_nettype wire

[rtl/bpil_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module bpil_ram #(
    parameter int WIDTH  = 48,
    parameter int DEPTH  = 16,
    parameter int ADDR_W = 4
) (
    input  wire logic              clk,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]  wr_data,
    input  wire logic              rd_en,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output logic      [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read port, data held while idle
    always_ff @(posedge clk) begin
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

[rtl/bounded_priority_insert_list.sv]
// Offer: from accept to result beat, the multiplier states M1 to M6 on the shared 32x32
//   multiplier, one saturating sum, a scan of the list (one entry a cycle, then a step to close
//   the last compare) and a commit state. Read, clear and unused command pass through a
//   finishing state that loads the result register.
// One item at a time; the next beat is taken once the result sits in the output register.
// Reset: registers to defaults, list empty; RAM contents are not cleared.
`default_nettype none
`include "bounded_priority_insert_list_defines.svh"

module bounded_priority_insert_list
    import bpil_pkg::*;
#(
    parameter int LIST_DEPTH = 16
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    // configuration writes
    input  wire logic                  cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
    // input channel
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire in_beat_t              s_data,
    // result channel
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output out_beat_t                  m_data
);

    localparam int AW = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
    localparam int LW = $clog2(LIST_DEPTH + 1);

    // Sequencer states
    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_M1   = 4'd1;
    localparam logic [3:0] ST_M2   = 4'd2;
    localparam logic [3:0] ST_M3   = 4'd3;
    localparam logic [3:0] ST_M4   = 4'd4;
    localparam logic [3:0] ST_M5   = 4'd5;
    localparam logic [3:0] ST_M6   = 4'd6;
    localparam logic [3:0] ST_SUM  = 4'd7;
    localparam logic [3:0] ST_SCAN = 4'd8;
    localparam logic [3:0] ST_TAIL = 4'd9;
    localparam logic [3:0] ST_RD   = 4'd10;
    localparam logic [3:0] ST_CTL  = 4'd11;

    logic [3:0]         state_reg;
    logic [4:0]         max_entries_reg;
    logic [31:0]        inv_far_sq_reg;
    logic [23:0]        inv_period_reg;
    logic [LW-1:0]      len_reg;
    in_beat_t           item_reg;
    logic               rvalid_reg;
    logic [31:0]        op_a_reg;
    logic [31:0]        op_b_reg;
    logic [63:0]        prod_reg;
    logic [31:0]        d_reg;
    logic signed [31:0] imp_reg;
    logic [LW-1:0]      rd_ptr_reg;
    logic               pend_reg;
    logic [AW-1:0]      proc_ptr_reg;
    logic               placed_reg;
    logic [AW-1:0]      at_reg;
    entry_t             carry_reg;
    logic               m_valid_reg;
    out_beat_t          m_data_reg;

    logic               out_free;
    logic               out_load_c;
    logic               s_fire;
    logic [63:0]        mul_c;
    logic signed [49:0] sum_c;
    logic signed [31:0] imp_sat_c;
    logic [CMP_W-1:0]   n_c;
    logic [CMP_W-1:0]   bound_c;
    logic [CMP_W-1:0]   depth_c;
    logic [CMP_W-1:0]   n1_c;
    logic [CMP_W-1:0]   n_new_c;
    logic [CMP_W-1:0]   at_fin_c;
    logic               acc_c;
    logic               rd_hit_c;
    logic               scan_issue_c;
    logic               hit_c;
    logic               tail_wr_c;
    entry_t             new_entry_c;
    entry_t             rd_entry;

    // RAM port signals
    logic               ram_wr_en;
    logic [AW-1:0]      ram_wr_addr;
    entry_t             ram_wr_data;
    logic               ram_rd_en;
    logic [AW-1:0]      ram_rd_addr;

    assign s_ready  = (state_reg == ST_IDLE);
    assign s_fire   = s_valid && s_ready;
    assign m_valid  = m_valid_reg;
    assign m_data   = m_data_reg;
    assign out_free = !m_valid_reg || m_ready;

    // Result register is loaded from one of the finishing states
    assign out_load_c = out_free && ((state_reg == ST_TAIL) || (state_reg == ST_RD) ||
                                     (state_reg == ST_CTL));

    // Shared multiplier
    assign mul_c = op_a_reg * op_b_reg;

    // Final importance: 1 - d + t^2*d, saturated to Q16.16
    always_comb begin
        sum_c = 50'sd65536 - $signed({18'b0, d_reg}) + $signed({2'b0, prod_reg[63:16]});
        if (sum_c > 50'sd2147483647) begin
            imp_sat_c = 32'sh7FFF_FFFF;
        end else if (sum_c < -50'sd2147483648) begin
            imp_sat_c = 32'sh8000_0000;
        end else begin
            imp_sat_c = sum_c[31:0];
        end
    end

    // Length, bound and placement bookkeeping
    always_comb begin
        n_c       = CMP_W'(len_reg);
        depth_c   = CMP_W'(LIST_DEPTH);
        bound_c   = (CMP_W'(max_entries_reg) < depth_c) ? CMP_W'(max_entries_reg) : depth_c;
        rd_hit_c  = CMP_W'(s_data.read_index) < n_c;
        tail_wr_c = (n_c < depth_c) && (placed_reg || (n_c < bound_c));
        if (placed_reg) begin
            n1_c = (n_c < depth_c) ? n_c + CMP_W'(1) : depth_c;
        end else if (n_c < bound_c) begin
            n1_c = n_c + CMP_W'(1);
        end else begin
            n1_c = n_c;
        end
        n_new_c  = (n1_c > bound_c) ? bound_c : n1_c;
        at_fin_c = placed_reg ? CMP_W'(at_reg) : n_c;
        acc_c    = (placed_reg || (n_c < bound_c)) && (at_fin_c < n_new_c);
    end

    // Scan: read entry i while entry i-1 is compared and rewritten
    assign new_entry_c  = '{importance: imp_reg, slot: item_reg.slot_id};
    assign scan_issue_c = (state_reg == ST_SCAN) && (CMP_W'(rd_ptr_reg) < n_c);
    assign hit_c        = pend_reg && !placed_reg && (imp_reg > rd_entry.importance);

    always_comb begin
        ram_rd_en   = scan_issue_c || (s_fire && (s_data.command == CMD_READ) && rd_hit_c);
        ram_rd_addr = scan_issue_c ? rd_ptr_reg[AW-1:0] : AW'(s_data.read_index);
        ram_wr_en   = 1'b0;
        ram_wr_addr = proc_ptr_reg;
        ram_wr_data = placed_reg ? carry_reg : new_entry_c;
        if (state_reg == ST_SCAN) begin
            ram_wr_en = pend_reg && (placed_reg || hit_c);
        end else if (state_reg == ST_TAIL) begin
            ram_wr_en   = out_free && tail_wr_c;
            ram_wr_addr = AW'(len_reg);
        end
    end

    bpil_ram #(
        .WIDTH  ($bits(entry_t)),
        .DEPTH  (LIST_DEPTH),
        .ADDR_W (AW)
    ) u_list_ram (
        .clk     (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (rd_entry)
    );

    // Payload registers: multiplier pipeline
    always_ff @(posedge aclk) begin
        prod_reg <= mul_c;
    end

    // Sequencer, configuration and result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            max_entries_reg <= MAX_ENTRIES_RST;
            inv_far_sq_reg  <= INV_FAR_SQ_RST;
            inv_period_reg  <= INV_PERIOD_RST;
            len_reg         <= '0;
            m_valid_reg     <= 1'b0;
            pend_reg        <= 1'b0;
            placed_reg      <= 1'b0;
            rd_ptr_reg      <= '0;
        end else begin
            // register writes
            if (cfg_wr_en) begin
                case (cfg_index)
                    CFG_MAX_ENTRIES: max_entries_reg <= cfg_wdata[4:0];
                    CFG_INV_FAR_SQ:  inv_far_sq_reg  <= cfg_wdata;
                    CFG_INV_PERIOD:  inv_period_reg  <= cfg_wdata[23:0];
                    default: ;
                endcase
            end

            // result beat valid: set on load, cleared once taken
            if (out_load_c) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE: begin
                    if (s_valid) begin
                        item_reg <= s_data;
                        unique case (s_data.command)
                            CMD_OFFER: begin
                                op_a_reg  <= s_data.distance_sq;
                                op_b_reg  <= inv_far_sq_reg;
                                state_reg <= ST_M1;
                            end
                            CMD_READ: begin
                                rvalid_reg <= rd_hit_c;
                                state_reg  <= ST_RD;
                            end
                            CMD_CLEAR, CMD_NOP: begin
                                state_reg <= ST_CTL;
                            end
                        endcase
                    end
                end
                ST_M1: begin
                    // distance product under way; load age operands
                    op_a_reg  <= 32'(item_reg.age_ms);
                    op_b_reg  <= 32'(inv_period_reg);
                    state_reg <= ST_M2;
                end
                ST_M2: begin
                    d_reg     <= sat_u31({24'b0, prod_reg[63:24]});
                    state_reg <= ST_M3;
                end
                ST_M3: begin
                    // square the scaled age
                    op_a_reg  <= sat_u31({8'b0, prod_reg[63:8]});
                    op_b_reg  <= sat_u31({8'b0, prod_reg[63:8]});
                    state_reg <= ST_M4;
                end
                ST_M4: begin
                    state_reg <= ST_M5;
                end
                ST_M5: begin
                    op_a_reg  <= sat_u31({16'b0, prod_reg[63:16]});
                    op_b_reg  <= d_reg;
                    state_reg <= ST_M6;
                end
                ST_M6: begin
                    state_reg <= ST_SUM;
                end
                ST_SUM: begin
                    imp_reg    <= imp_sat_c;
                    rd_ptr_reg <= '0;
                    pend_reg   <= 1'b0;
                    placed_reg <= 1'b0;
                    state_reg  <= ST_SCAN;
                end
                ST_SCAN: begin
                    if (scan_issue_c) begin
                        rd_ptr_reg   <= rd_ptr_reg + LW'(1);
                        proc_ptr_reg <= rd_ptr_reg[AW-1:0];
                        pend_reg     <= 1'b1;
                    end else begin
                        pend_reg <= 1'b0;
                    end
                    // displaced entries ripple one place down
                    if (pend_reg && (placed_reg || hit_c)) begin
                        carry_reg <= rd_entry;
                    end
                    if (hit_c) begin
                        placed_reg <= 1'b1;
                        at_reg     <= proc_ptr_reg;
                    end
                    if (!scan_issue_c && !pend_reg) begin
                        state_reg <= ST_TAIL;
                    end
                end
                ST_TAIL: begin
                    if (out_free) begin
                        len_reg                     <= LW'(n_new_c);
                        m_data_reg.accepted         <= acc_c;
                        m_data_reg.position         <= acc_c ? 4'(at_fin_c) : 4'd0;
                        m_data_reg.entry_count      <= 5'(n_new_c);
                        m_data_reg.entry_valid      <= 1'b0;
                        m_data_reg.entry_importance <= imp_reg;
                        m_data_reg.entry_slot       <= item_reg.slot_id;
                        state_reg                   <= ST_IDLE;
                    end
                end
                ST_RD: begin
                    if (out_free) begin
                        m_data_reg.accepted         <= 1'b0;
                        m_data_reg.position         <= 4'd0;
                        m_data_reg.entry_count      <= 5'(len_reg);
                        m_data_reg.entry_valid      <= rvalid_reg;
                        m_data_reg.entry_importance <= rvalid_reg ? rd_entry.importance : '0;
                        m_data_reg.entry_slot       <= rvalid_reg ? rd_entry.slot : '0;
                        state_reg                   <= ST_IDLE;
                    end
                end
                ST_CTL: begin
                    if (out_free) begin
                        if (item_reg.command == CMD_CLEAR) begin
                            len_reg <= '0;
                        end
                        m_data_reg.accepted         <= 1'b0;
                        m_data_reg.position         <= 4'd0;
                        m_data_reg.entry_count      <= (item_reg.command == CMD_CLEAR) ?
                                                       5'd0 : 5'(len_reg);
                        m_data_reg.entry_valid      <= 1'b0;
                        m_data_reg.entry_importance <= '0;
                        m_data_reg.entry_slot       <= '0;
                        state_reg                   <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // List length never exceeds the storage
    `BPIL_ASSERT_IMPLY(a_len_in_depth, aclk, aresetn, 1'b1, CMP_W'(len_reg) <= CMP_W'(LIST_DEPTH))
    // Scan only compares entries that belong to the list
    `BPIL_ASSERT_IMPLY(a_scan_in_list, aclk, aresetn, pend_reg, CMP_W'(proc_ptr_reg) < CMP_W'(len_reg))
    // The list is only written while an offer is placed
    `BPIL_ASSERT_IMPLY(a_wr_in_offer, aclk, aresetn, ram_wr_en, (state_reg == ST_SCAN) || (state_reg == ST_TAIL))
    // An accepted offer leaves a non-empty list
    `BPIL_ASSERT_IMPLY(a_acc_count, aclk, aresetn, m_valid_reg && m_data_reg.accepted, m_data_reg.entry_count != 5'd0)
    // An accepted offer starts the multiply sequence
    `BPIL_ASSERT_NEXT(a_offer_start, aclk, aresetn, s_fire && (s_data.command == CMD_OFFER), state_reg == ST_M1)

endmodule

`default_nettype wire

[bench/rank_list_checker.sv]
// Result checker for the bounded priority insert list: predicts every result beat and compares.
module rank_list_checker
    import bpil_pkg::*;
#(
    parameter int DEPTH = 16
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic                  s_valid,
    input  logic                  s_ready,
    input  in_beat_t              s_data,
    input  logic                  m_valid,
    input  logic                  m_ready,
    input  out_beat_t             m_data,
    output int                    fail_count,
    output int                    outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int PRINT_CAP = 100;

    // Register shadows
    logic [4:0]  bound_reg;
    logic [31:0] far_recip;
    logic [23:0] period_recip;

    // Shadow of the ranked list
    logic signed [31:0] ranked_imp [DEPTH];
    logic [15:0]        ranked_slot [DEPTH];
    int                 ranked_len;

    out_beat_t expected_results [$];
    int        mismatches = 0;

    assign fail_count = mismatches;

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        mismatches++;
        if (mismatches <= PRINT_CAP)
            $display("%0t: mismatch on %s: got %08h, expected %08h", $time, what, got, want);
    endtask

    // Signed Q16.16 importance of one candidate under the current registers
    function automatic logic signed [31:0] importance_for(input logic [31:0] dist_sq,
                                                          input logic [19:0] age);
        logic [63:0]        near_d, life, life_sq, rest, boost;
        logic signed [63:0] inv_d, total;
        near_d = ({32'd0, dist_sq} * {32'd0, far_recip}) >> 24;
        if (near_d > 64'h7FFF_FFFF) near_d = 64'h7FFF_FFFF;
        // near_d stays below 2^31, so 1 - d cannot underflow 32 bits
        inv_d = 64'sd65536 - $signed(near_d);
        life = ({44'd0, age} * {40'd0, period_recip}) >> 8;
        if (life > 64'h7FFF_FFFF) life = 64'h7FFF_FFFF;
        life_sq = (life * life) >> 16;
        if (life_sq > 64'h7FFF_FFFF) life_sq = 64'h7FFF_FFFF;
        rest = $unsigned(64'sd65536 - inv_d);
        boost = (life_sq * rest) >> 16;
        total = inv_d + $signed(boost);
        if (total > 64'sh7FFF_FFFF) total = 64'sh7FFF_FFFF;
        if (total < -64'sh8000_0000) total = -64'sh8000_0000;
        return total[31:0];
    endfunction

    // Apply one accepted beat to the shadow list and build its result
    function automatic out_beat_t rank_list_step(input in_beat_t b);
        out_beat_t          r;
        logic signed [31:0] imp;
        int                 bound, n, at, last, i;
        bit                 placed;
        r = '0;
        placed = 1'b0;
        case (b.command)
            CMD_OFFER: begin
                bound = (int'(bound_reg) < DEPTH) ? int'(bound_reg) : DEPTH;
                imp = importance_for(b.distance_sq, b.age_ms);
                n = ranked_len;
                at = n;
                // first entry strictly weaker than the offer
                for (i = 0; i < n; i++)
                    if (at == n && imp > ranked_imp[i]) at = i;
                if (at < n) begin
                    last = (n < DEPTH) ? n : DEPTH - 1;
                    for (i = last; i > at; i--) begin
                        ranked_imp[i] = ranked_imp[i-1];
                        ranked_slot[i] = ranked_slot[i-1];
                    end
                    ranked_imp[at] = imp;
                    ranked_slot[at] = b.slot_id;
                    n = (n < DEPTH) ? n + 1 : DEPTH;
                    placed = 1'b1;
                end else if (n < bound) begin
                    ranked_imp[n] = imp;
                    ranked_slot[n] = b.slot_id;
                    n++;
                    placed = 1'b1;
                end
                // tail cut, also applies a lowered bound
                if (n > bound) n = bound;
                ranked_len = n;
                if (placed && at < n) begin
                    r.accepted = 1'b1;
                    r.position = 4'(at);
                end
                r.entry_importance = imp;
                r.entry_slot = b.slot_id;
            end
            CMD_READ: begin
                if (int'(b.read_index) < ranked_len) begin
                    r.entry_valid = 1'b1;
                    r.entry_importance = ranked_imp[b.read_index];
                    r.entry_slot = ranked_slot[b.read_index];
                end
            end
            CMD_CLEAR: ranked_len = 0;
            default: ;
        endcase
        r.entry_count = 5'(ranked_len);
        return r;
    endfunction

    always @(posedge aclk) begin
        out_beat_t want;
        if (!aresetn) begin
            bound_reg <= MAX_ENTRIES_RST;
            far_recip <= INV_FAR_SQ_RST;
            period_recip <= INV_PERIOD_RST;
            for (int i = 0; i < DEPTH; i++) begin
                ranked_imp[i] = '0;
                ranked_slot[i] = '0;
            end
            ranked_len = 0;
            expected_results.delete();
        end else begin
            // result beat against the oldest expectation
            if (m_valid && m_ready) begin
                if (expected_results.size() == 0) begin
                    report_mismatch("unexpected result beat", 32'(m_data.entry_slot), '0);
                end else begin
                    want = expected_results.pop_front();
                    if (m_data.accepted !== want.accepted)
                        report_mismatch("accepted", 32'(m_data.accepted), 32'(want.accepted));
                    if (m_data.position !== want.position)
                        report_mismatch("position", 32'(m_data.position), 32'(want.position));
                    if (m_data.entry_count !== want.entry_count)
                        report_mismatch("entry_count", 32'(m_data.entry_count),
                                        32'(want.entry_count));
                    if (m_data.entry_valid !== want.entry_valid)
                        report_mismatch("entry_valid", 32'(m_data.entry_valid),
                                        32'(want.entry_valid));
                    if (m_data.entry_importance !== want.entry_importance)
                        report_mismatch("entry_importance", m_data.entry_importance,
                                        want.entry_importance);
                    if (m_data.entry_slot !== want.entry_slot)
                        report_mismatch("entry_slot", 32'(m_data.entry_slot),
                                        32'(want.entry_slot));
                end
            end
            // input beat: predict its result now, list state is updated in order
            if (s_valid && s_ready)
                expected_results.insert(expected_results.size(), rank_list_step(s_data));
            // register writes should only land while the block is idle; the block does not enforce it
            if (cfg_wr_en) begin
                case (cfg_index)
                    CFG_MAX_ENTRIES: bound_reg <= cfg_wdata[4:0];
                    CFG_INV_FAR_SQ:  far_recip <= cfg_wdata;
                    CFG_INV_PERIOD:  period_recip <= cfg_wdata[23:0];
                    default: ;
                endcase
            end
        end
        outstanding <= expected_results.size();
    end

endmodule

[bench/testbench.sv]
// Top of the bounded priority insert list bench: clock, reset, stimulus, idling and verdict.
module testbench
    import bpil_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH           = 16;
    localparam int BLOCKS          = 5;
    localparam int ITEMS_PER_BLOCK = 84;
    localparam int HOLD_CYCLES     = 300;
    localparam int SETTLE_CYCLES   = 40;
    localparam int CYCLE_LIMIT     = 1_000_000;

    logic                  aclk;
    logic                  aresetn;
    logic                  cfg_wr_en;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;
    logic                  s_valid;
    logic                  s_ready;
    in_beat_t              s_data;
    logic                  m_valid;
    logic                  m_ready;
    out_beat_t             m_data;

    int fail_count;
    int outstanding;
    int send_idle_pct = 25;
    int recv_idle_pct = 75;
    bit hold_req = 1'b0;
    int cycle_count = 0;

    // last offered candidate, reused to force importance ties
    logic [31:0] last_dist = '0;
    logic [19:0] last_age = '0;

    bounded_priority_insert_list #(
        .LIST_DEPTH(DEPTH)
    ) uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    rank_list_checker #(
        .DEPTH(DEPTH)
    ) checker_i (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data),
        .fail_count  (fail_count),
        .outstanding (outstanding)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // Run watchdog
    always @(posedge aclk) cycle_count <= cycle_count + 1;

    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("[FAIL] regression broken");
        $finish;
    end

    // Result side: random stalls, plus one long hold-off on request
    initial begin
        m_ready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_req) begin
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                hold_req = 1'b0;
            end
            m_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    function automatic in_beat_t offer_beat(input logic [15:0] slot, input logic [31:0] dist_sq,
                                            input logic [19:0] age);
        in_beat_t b;
        b.command = CMD_OFFER;
        b.slot_id = slot;
        b.distance_sq = dist_sq;
        b.age_ms = age;
        b.read_index = 4'($urandom);
        return b;
    endfunction

    // Non-offer beat; the unused fields carry noise
    function automatic in_beat_t cmd_beat(input logic [1:0] cmd, input logic [3:0] idx);
        in_beat_t b;
        b.command = cmd;
        b.slot_id = 16'($urandom);
        b.distance_sq = $urandom;
        b.age_ms = 20'($urandom);
        b.read_index = idx;
        return b;
    endfunction

    function automatic in_beat_t random_beat();
        in_beat_t b;
        int       pick;
        b.slot_id = 16'($urandom);
        b.read_index = 4'($urandom);
        case ($urandom_range(3))
            0: b.distance_sq = $urandom;
            1: b.distance_sq = $urandom >> $urandom_range(31);
            2: b.distance_sq = last_dist;
            default: b.distance_sq = $urandom_range(4096);
        endcase
        case ($urandom_range(3))
            0: b.age_ms = 20'($urandom);
            1: b.age_ms = 20'($urandom) >> $urandom_range(19);
            2: b.age_ms = last_age;
            default: b.age_ms = 20'($urandom_range(1000));
        endcase
        last_dist = b.distance_sq;
        last_age = b.age_ms;
        // mostly offers so lists fill up; clears are rare
        pick = $urandom_range(99);
        if (pick < 62)      b.command = CMD_OFFER;
        else if (pick < 94) b.command = CMD_READ;
        else if (pick < 97) b.command = CMD_CLEAR;
        else                b.command = CMD_NOP;
        return b;
    endfunction

    // Offer one beat; valid stays high after the handshake for back-to-back beats
    task automatic send_beat(input in_beat_t b);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= b;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic wait_drained();
        @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
    endtask

    // Drop valid in the handshake step and wait for every result
    task automatic halt_and_drain();
        s_valid <= 1'b0;
        wait_drained();
    endtask

    task automatic send_plan(input in_beat_t plan [$]);
        foreach (plan[i]) send_beat(plan[i]);
        halt_and_drain();
    endtask

    // Write all three registers; unused upper data bits carry noise
    task automatic program_regs(input logic [4:0] bound, input logic [31:0] far,
                                input logic [23:0] period);
        cfg_wr_en <= 1'b1;
        cfg_index <= CFG_MAX_ENTRIES;
        cfg_wdata <= ($urandom & 32'hFFFF_FFE0) | 32'(bound);
        @(posedge aclk);
        cfg_index <= CFG_INV_FAR_SQ;
        cfg_wdata <= far;
        @(posedge aclk);
        cfg_index <= CFG_INV_PERIOD;
        cfg_wdata <= ($urandom & 32'hFF00_0000) | 32'(period);
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    initial begin
        logic [4:0]  bound;
        logic [31:0] far;
        logic [23:0] period;
        aresetn <= 1'b0;
        cfg_wr_en <= 1'b0;
        cfg_index <= CFG_MAX_ENTRIES;
        cfg_wdata <= '0;
        s_valid <= 1'b0;
        s_data <= '0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Register defaults: bound of one, ties, weaker offers, replacement, read range
        send_plan({cmd_beat(CMD_READ, 4'd0),
                   offer_beat(16'h0000, 32'h0000_0000, 20'h00000),
                   offer_beat(16'hFFFF, 32'h0000_0000, 20'h00000),
                   offer_beat(16'h1234, 32'hFFFF_FFFF, 20'h00000),
                   offer_beat(16'h0005, 32'h0000_0100, 20'hFFFFF),
                   cmd_beat(CMD_READ, 4'd0),
                   cmd_beat(CMD_READ, 4'd1),
                   cmd_beat(CMD_READ, 4'd15),
                   cmd_beat(CMD_NOP, 4'd0),
                   cmd_beat(CMD_CLEAR, 4'd0),
                   cmd_beat(CMD_READ, 4'd0),
                   offer_beat(16'h0007, 32'h0000_0000, 20'h00000)});

        // Bound of zero: old entry still readable, next offer empties the list
        program_regs(5'd0, 32'h0, 24'h0);
        send_plan({cmd_beat(CMD_READ, 4'd0),
                   offer_beat(16'hA5A5, 32'hFFFF_FFFF, 20'hFFFFF),
                   cmd_beat(CMD_READ, 4'd0)});

        // Largest bound and registers: saturation at both ends, equal importance
        program_regs(5'd31, 32'hFFFF_FFFF, 24'hFF_FFFF);
        send_plan({offer_beat(16'h0001, 32'hFFFF_FFFF, 20'hFFFFF),
                   offer_beat(16'h0002, 32'hFFFF_FFFF, 20'h00000),
                   offer_beat(16'h0003, 32'h0000_0000, 20'h00000),
                   offer_beat(16'h0004, 32'h0000_0000, 20'h00000),
                   cmd_beat(CMD_READ, 4'd0),
                   cmd_beat(CMD_READ, 4'd3)});

        // Lowered bound: longer list stays readable until the next offer cuts it
        program_regs(5'd2, 32'hFFFF_FFFF, 24'hFF_FFFF);
        send_plan({cmd_beat(CMD_READ, 4'd3),
                   offer_beat(16'h0005, 32'h0000_0100, 20'h00000),
                   offer_beat(16'h0006, 32'h0000_0001, 20'hFFFFF),
                   cmd_beat(CMD_READ, 4'd1)});

        // Random part: three idling mixes, several register settings each
        for (int ph = 0; ph < 3; ph++) begin
            send_idle_pct = (ph == 0) ? 25 : (ph == 1) ? 75 : 0;
            recv_idle_pct = (ph == 0) ? 75 : (ph == 1) ? 25 : 0;
            for (int blk = 0; blk < BLOCKS; blk++) begin
                case ($urandom_range(7))
                    0: bound = 5'd0;
                    1: bound = 5'd1;
                    2: bound = 5'd16;
                    3: bound = 5'($urandom_range(17, 31));
                    default: bound = 5'($urandom_range(2, 16));
                endcase
                case ($urandom_range(4))
                    0: far = 32'h0;
                    1: far = 32'hFFFF_FFFF;
                    2: far = $urandom;
                    default: far = $urandom >> $urandom_range(8, 24);
                endcase
                case ($urandom_range(3))
                    0: period = 24'h0;
                    1: period = 24'hFF_FFFF;
                    2: period = INV_PERIOD_RST;
                    default: period = 24'($urandom) >> $urandom_range(16);
                endcase
                program_regs(bound, far, period);
                // long result stall while the sender keeps offering
                if (ph == 2 && blk == 1) hold_req = 1'b1;
                for (int k = 0; k < ITEMS_PER_BLOCK; k++) begin
                    // sender pause until every result is back
                    if (blk == 0 && k == ITEMS_PER_BLOCK / 2) halt_and_drain();
                    send_beat(random_beat());
                end
                halt_and_drain();
            end
        end

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (fail_count == 0 && outstanding == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
